// ----- design/nbai_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// nbai_pkg
// Shared types and constants of the nearest beam angle index block.
// ----------------------------------------------------------------------------
package nbai_pkg;

   localparam int AngleWidth   = 20;
   localparam int SpacingWidth = 16;
   localparam int LengthWidth  = 7;
   localparam int SlotWidth    = 6;
   localparam int IndexWidth   = 6;
   localparam int DistWidth    = 21;
   localparam int RangeWidth   = 22;
   localparam int CsrAddrWidth = 4;
   localparam int CsrDataWidth = 32;

   localparam logic [LengthWidth-1:0]  TableLengthReset     = 7'd64;
   localparam logic                    DescendingOrderReset = 1'b0;
   localparam logic [SpacingWidth-1:0] AverageSpacingReset  = 16'd0;

   typedef enum logic [0:0] {
      ACTION_QUERY = 1'b0,
      ACTION_WRITE = 1'b1
   } action_type;

   typedef enum logic [1:0] {
      REG_TABLE_LENGTH     = 2'd0,
      REG_DESCENDING_ORDER = 2'd1,
      REG_AVERAGE_SPACING  = 2'd2
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ_FIRST,
      ST_READ_LAST,
      ST_SCAN,
      ST_PUSH
   } state_type;

   typedef struct packed {
      action_type                    action;
      logic signed [AngleWidth-1:0]  query_angle;
      logic [SlotWidth-1:0]          entry_slot;
      logic signed [AngleWidth-1:0]  entry_angle;
   } req_word_type;

   typedef struct packed {
      logic                  in_range;
      logic [IndexWidth-1:0] beam_index;
   } rsp_word_type;

   typedef struct packed {
      logic [LengthWidth-1:0]  table_length;
      logic                    descending_order;
      logic [SpacingWidth-1:0] average_spacing;
   } cfg_type;

   // Absolute difference of two angles; the magnitude fits in 21 bits.
   function automatic logic [DistWidth-1:0] abs_dist(
      input logic signed [AngleWidth-1:0] a,
      input logic signed [AngleWidth-1:0] b
   );
      logic signed [RangeWidth-1:0] diff;
      logic signed [RangeWidth-1:0] mag;
      diff = RangeWidth'(a) - RangeWidth'(b);
      mag  = (diff < 0) ? -diff : diff;
      return mag[DistWidth-1:0];
   endfunction

endpackage
`default_nettype wire

// ----- design/nearest_beam_angle_index.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_beam_angle_index
// Maps a beam angle to the index of the nearest entry of a monotone table.
// ----------------------------------------------------------------------------
// A write word stores one table angle and gives no result.
// A query word gives one result and occupies the block until it is done:
// the first and last entries are read for the range check, which ends a
// query that falls outside the table span plus margin; otherwise the scan
// visits one entry per cycle, among the n valid entries, through the single
// read port of the table memory. A last step hands the result to the output
// register. That register lets a new word in while a result still waits to
// be taken. The table holds no defined value until written, and no query may
// reach an entry that was never written.
module nearest_beam_angle_index
   import nbai_pkg::*;
#(
   parameter int TABLE_DEPTH = 64
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire req_word_type            req_word,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output rsp_word_type                 rsp_word,
   input  wire logic                    csr_psel,
   input  wire logic                    csr_penable,
   input  wire logic                    csr_pwrite,
   input  wire logic [CsrAddrWidth-1:0] csr_paddr,
   input  wire logic [CsrDataWidth-1:0] csr_pwdata,
   output logic      [CsrDataWidth-1:0] csr_prdata,
   output logic                         csr_pready
);

   localparam int AW = $clog2(TABLE_DEPTH);

   cfg_type                      cfg;
   logic                         ram_wr_en;
   logic [AW-1:0]                ram_wr_addr;
   logic signed [AngleWidth-1:0] ram_wr_data;
   logic                         ram_rd_en;
   logic [AW-1:0]                ram_rd_addr;
   logic signed [AngleWidth-1:0] ram_rd_data;

   nbai_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   nbai_ram #(
      .WIDTH (AngleWidth),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   nbai_ctrl #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_word    (rsp_word),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

endmodule
`default_nettype wire

// ----- design/nbai_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// nbai_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module nbai_ram #(
   parameter int WIDTH = 20,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ----- design/nbai_csr.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// nbai_csr
// Configuration registers behind an APB-style port.
// ----------------------------------------------------------------------------
module nbai_csr
   import nbai_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    csr_psel,
   input  wire logic                    csr_penable,
   input  wire logic                    csr_pwrite,
   input  wire logic [CsrAddrWidth-1:0] csr_paddr,
   input  wire logic [CsrDataWidth-1:0] csr_pwdata,
   output logic      [CsrDataWidth-1:0] csr_prdata,
   output logic                         csr_pready,
   output cfg_type                      cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type reg_index;
   logic          wr_strobe;

   assign csr_pready = 1'b1;
   assign reg_index  = reg_index_type'(csr_paddr[CsrAddrWidth-1:2]);
   assign wr_strobe  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_strobe) begin
         unique case (reg_index)
            REG_TABLE_LENGTH: begin
               cfg_in.table_length = csr_pwdata[LengthWidth-1:0];
            end
            REG_DESCENDING_ORDER: begin
               cfg_in.descending_order = csr_pwdata[0];
            end
            REG_AVERAGE_SPACING: begin
               cfg_in.average_spacing = csr_pwdata[SpacingWidth-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_TABLE_LENGTH:     csr_prdata = CsrDataWidth'(cfg_ff.table_length);
         REG_DESCENDING_ORDER: csr_prdata = CsrDataWidth'(cfg_ff.descending_order);
         REG_AVERAGE_SPACING:  csr_prdata = CsrDataWidth'(cfg_ff.average_spacing);
         default:              csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.table_length     <= TableLengthReset;
         cfg_ff.descending_order <= DescendingOrderReset;
         cfg_ff.average_spacing  <= AverageSpacingReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

// ----- design/nbai_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// nbai_ctrl
// Sequencer and datapath: table writes, range check and the linear scan.
// ----------------------------------------------------------------------------
module nbai_ctrl
   import nbai_pkg::*;
#(
   parameter int TABLE_DEPTH = 64
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire cfg_type                        cfg,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire req_word_type                   req_word,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output rsp_word_type                        rsp_word,
   output logic                                ram_wr_en,
   output logic [$clog2(TABLE_DEPTH)-1:0]      ram_wr_addr,
   output logic signed [AngleWidth-1:0]        ram_wr_data,
   output logic                                ram_rd_en,
   output logic [$clog2(TABLE_DEPTH)-1:0]      ram_rd_addr,
   input  wire logic signed [AngleWidth-1:0]   ram_rd_data
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int LW = (CW > LengthWidth) ? CW : LengthWidth;
   localparam int SW = ((AW > SlotWidth) ? AW : SlotWidth) + 1;
   localparam int XW = (CW > IndexWidth) ? CW : IndexWidth;

   state_type state_ff, state_in;

   logic signed [AngleWidth-1:0] query_ff, query_in;
   logic signed [AngleWidth-1:0] first_ff, first_in;
   logic [DistWidth-1:0]         old_dst_ff, old_dst_in;
   logic [CW-1:0]                idx_ff, idx_in;
   rsp_word_type                 result_ff, result_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   rsp_word_type                 rsp_word_ff, rsp_word_in;

   logic                         accept;
   logic                         accept_query;
   logic [LW-1:0]                len_ext;
   logic [CW-1:0]                count;
   logic [CW-1:0]                last_idx;
   logic [CW-1:0]                idx_next;
   logic [CW-1:0]                idx_prev;
   logic [XW-1:0]                idx_prev_ext;
   logic [SW-1:0]                slot_ext;
   logic                         slot_ok;
   logic signed [RangeWidth-1:0] q_x, f_x, l_x, s_x;
   logic                         range_ok;
   logic [DistWidth-1:0]         cur_dst;
   logic                         scan_end;
   logic                         rsp_free;

   assign accept       = req_valid && !req_stall;
   assign accept_query = accept && (req_word.action == ACTION_QUERY);

   // Number of valid entries: zero counts as one, large values saturate.
   assign len_ext = LW'(cfg.table_length);
   always_comb begin
      priority if (len_ext == '0) begin
         count = CW'(1);
      end else if (len_ext > LW'(TABLE_DEPTH)) begin
         count = CW'(TABLE_DEPTH);
      end else begin
         count = len_ext[CW-1:0];
      end
   end

   assign last_idx     = count - CW'(1);
   assign idx_next     = idx_ff + CW'(1);
   assign idx_prev     = idx_ff - CW'(1);
   assign idx_prev_ext = XW'(idx_prev);

   // Table writes go straight to the memory; slots past the depth are dropped.
   assign slot_ext    = SW'(req_word.entry_slot);
   assign slot_ok     = slot_ext < SW'(TABLE_DEPTH);
   assign ram_wr_en   = accept && (req_word.action == ACTION_WRITE) && slot_ok;
   assign ram_wr_addr = slot_ext[AW-1:0];
   assign ram_wr_data = req_word.entry_angle;

   // Range check, done when the last entry comes out of the memory.
   assign q_x = RangeWidth'(query_ff);
   assign f_x = RangeWidth'(first_ff);
   assign l_x = RangeWidth'(ram_rd_data);
   assign s_x = signed'(RangeWidth'(cfg.average_spacing));
   always_comb begin
      if (cfg.descending_order) begin
         range_ok = !(q_x > f_x + s_x) && !(q_x < l_x - s_x);
      end else begin
         range_ok = !(q_x < f_x - s_x) && !(q_x > l_x + s_x);
      end
   end

   // The scan stops past the last valid entry or once the distance no
   // longer strictly falls; the entry before idx_ff is the answer.
   assign cur_dst  = abs_dist(query_ff, ram_rd_data);
   assign scan_end = (idx_ff == count) || !(cur_dst < old_dst_ff);
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept_query) begin
               state_in = ST_READ_FIRST;
            end
         end
         ST_READ_FIRST: begin
            state_in = ST_READ_LAST;
         end
         ST_READ_LAST: begin
            state_in = range_ok ? ST_SCAN : ST_PUSH;
         end
         ST_SCAN: begin
            if (scan_end) begin
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State outputs: stall and the memory read port.
   always_comb begin
      req_stall   = 1'b1;
      ram_rd_en   = 1'b0;
      ram_rd_addr = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall   = 1'b0;
            ram_rd_en   = accept_query;
            ram_rd_addr = '0;
         end
         ST_READ_FIRST: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = last_idx[AW-1:0];
         end
         ST_READ_LAST: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = AW'(1);
         end
         ST_SCAN: begin
            // Fetch the following entry while this one is compared.
            ram_rd_en   = 1'b1;
            ram_rd_addr = idx_next[AW-1:0];
         end
         ST_PUSH: begin
            ram_rd_en   = 1'b0;
         end
         default: begin
            ram_rd_en   = 1'b0;
         end
      endcase
   end

   // Datapath next values.
   always_comb begin
      query_in   = query_ff;
      first_in   = first_ff;
      old_dst_in = old_dst_ff;
      idx_in     = idx_ff;
      result_in  = result_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept_query) begin
               query_in = req_word.query_angle;
            end
         end
         ST_READ_FIRST: begin
            first_in = ram_rd_data;
         end
         ST_READ_LAST: begin
            old_dst_in           = abs_dist(query_ff, first_ff);
            idx_in               = CW'(1);
            result_in.in_range   = 1'b0;
            result_in.beam_index = '0;
         end
         ST_SCAN: begin
            if (scan_end) begin
               result_in.in_range   = 1'b1;
               result_in.beam_index = idx_prev_ext[IndexWidth-1:0];
            end else begin
               old_dst_in = cur_dst;
               idx_in     = idx_next;
            end
         end
         ST_PUSH: begin
            result_in = result_ff;
         end
         default: begin
            result_in = result_ff;
         end
      endcase
   end

   // Output register: loaded from the finished result when the slot frees.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_word_in  = rsp_word_ff;
      if ((state_ff == ST_PUSH) && rsp_free) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = result_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      query_ff    <= query_in;
      first_ff    <= first_in;
      old_dst_ff  <= old_dst_in;
      idx_ff      <= idx_in;
      result_ff   <= result_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule
`default_nettype wire
